/* hdl/asrm_pkg.sv */
// Package for the aux send/return mixer: sample and gain formats,
// register indexes, mode bit positions and mix limits.
// No dependencies.
`timescale 1ns / 1ps

package asrm_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC_BITS    = SAMPLE_BITS - 5;
  localparam int GAIN_BITS    = 17;
  localparam int GAIN_FRAC    = 16;
  localparam int PROD_BITS    = SAMPLE_BITS + GAIN_BITS;
  localparam int MIX_BITS     = SAMPLE_BITS + 2;
  localparam int CFG_IDX_BITS = 4;
  localparam int MODE_BITS    = 7;
  localparam int NUM_BUS      = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [GAIN_BITS-1:0]   gain_t;
  typedef logic signed [MIX_BITS-1:0]    mix_t;
  typedef logic        [MODE_BITS-1:0]   mode_t;

  localparam gain_t UNITY_GAIN   = gain_t'(1 << GAIN_FRAC);
  localparam gain_t HALF_GAIN    = gain_t'(1 << (GAIN_FRAC - 1));
  localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1 << (GAIN_FRAC - 1));

  // +/- 10 V
  localparam mix_t    MIX_MAX_W = mix_t'(10 << FRAC_BITS);
  localparam mix_t    MIX_MIN_W = -mix_t'(10 << FRAC_BITS);
  localparam sample_t MIX_MAX   = sample_t'(10 << FRAC_BITS);
  localparam sample_t MIX_MIN   = -sample_t'(10 << FRAC_BITS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DRY_GAIN      = 4'd0,
    CFG_SEND_A_GAIN   = 4'd1,
    CFG_SEND_B_GAIN   = 4'd2,
    CFG_SEND_C_GAIN   = 4'd3,
    CFG_RETURN_A_GAIN = 4'd4,
    CFG_RETURN_B_GAIN = 4'd5,
    CFG_RETURN_C_GAIN = 4'd6,
    CFG_MODE_BITS     = 4'd7
  } cfg_idx_e;

  // mode bit positions
  localparam int MODE_PRE_A   = 0;
  localparam int MODE_MAIN_R  = 3;
  localparam int MODE_RET_R_A = 4;

endpackage

/* hdl/asrm_gain.sv */
// Gain multiplier: signed sample times unsigned Q1.16 gain, rounded to
// the nearest sample LSB with ties toward plus infinity.
// Depends on asrm_pkg.
`timescale 1ns / 1ps

module asrm_gain (
  input  asrm_pkg::sample_t s_i,
  input  asrm_pkg::gain_t   g_i,
  output asrm_pkg::sample_t y_o
);
  import asrm_pkg::*;

  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] rnd;

  always_comb begin
    prod = PROD_BITS'(s_i) * PROD_BITS'($signed({1'b0, g_i}));
    // add half an LSB, then an arithmetic shift floors
    rnd  = prod + $signed(ROUND_HALF);
  end

  // gain is at most unity, so the scaled value always fits the sample width
  assign y_o = rnd[GAIN_FRAC+SAMPLE_BITS-1:GAIN_FRAC];

endmodule

/* hdl/aux_send_return_mixer_top.sv */
// Top level of the aux send/return mixer: configuration registers and
// the three-stage mixing pipeline.
// Depends on asrm_pkg and asrm_gain.
`timescale 1ns / 1ps

// Usage:
//   One input transfer carries one stereo frame: main left/right and the
//   left/right samples of returns A, B and C (signed Q4.19 volts). One
//   output transfer carries the six send samples and the saturated main
//   mix. Both channels use valid/ready.
//   Configuration writes go through cfg_valid_i/cfg_index_i/cfg_data_i;
//   cfg_ready_o is always high. Gains are Q1.16 and saturate at unity
//   on write. Indexes 8 and above are ignored. Write only while idle.
//   A frame moves through the stage 1, 2 and 3 registers in order; output
//   valid rises when it reaches stage 3. Throughput is one frame per cycle
//   while the receiver does not stall: stage 1 holds the dry and return
//   products, stage 2 the send products and the four-way mix sum, stage 3
//   the clamp and output register.
//   When the receiver stalls, the whole pipeline holds and in_ready_o
//   drops; nothing is lost or repeated.
//   Reset empties the pipeline and loads the default gains (dry unity,
//   all others half) and clears the mode bits.

module aux_send_return_mixer_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [asrm_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  asrm_pkg::gain_t                      cfg_data_i,
  // input frame
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  asrm_pkg::sample_t                    main_left_i,
  input  asrm_pkg::sample_t                    main_right_i,
  input  asrm_pkg::sample_t                    ret_a_left_i,
  input  asrm_pkg::sample_t                    ret_a_right_i,
  input  asrm_pkg::sample_t                    ret_b_left_i,
  input  asrm_pkg::sample_t                    ret_b_right_i,
  input  asrm_pkg::sample_t                    ret_c_left_i,
  input  asrm_pkg::sample_t                    ret_c_right_i,
  // output frame
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output asrm_pkg::sample_t                    send_a_left_o,
  output asrm_pkg::sample_t                    send_a_right_o,
  output asrm_pkg::sample_t                    send_b_left_o,
  output asrm_pkg::sample_t                    send_b_right_o,
  output asrm_pkg::sample_t                    send_c_left_o,
  output asrm_pkg::sample_t                    send_c_right_o,
  output asrm_pkg::sample_t                    mix_left_o,
  output asrm_pkg::sample_t                    mix_right_o
);
  import asrm_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  gain_t dry_gain_q;
  gain_t send_gain_q [NUM_BUS];
  gain_t ret_gain_q  [NUM_BUS];
  mode_t mode_q;
  gain_t cfg_gain;

  assign cfg_ready_o = 1'b1;
  assign cfg_gain    = (cfg_data_i > UNITY_GAIN) ? UNITY_GAIN : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_gain_q <= UNITY_GAIN;
      for (int i = 0; i < NUM_BUS; i++) begin
        send_gain_q[i] <= HALF_GAIN;
        ret_gain_q[i]  <= HALF_GAIN;
      end
      mode_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DRY_GAIN:      dry_gain_q     <= cfg_gain;
        CFG_SEND_A_GAIN:   send_gain_q[0] <= cfg_gain;
        CFG_SEND_B_GAIN:   send_gain_q[1] <= cfg_gain;
        CFG_SEND_C_GAIN:   send_gain_q[2] <= cfg_gain;
        CFG_RETURN_A_GAIN: ret_gain_q[0]  <= cfg_gain;
        CFG_RETURN_B_GAIN: ret_gain_q[1]  <= cfg_gain;
        CFG_RETURN_C_GAIN: ret_gain_q[2]  <= cfg_gain;
        CFG_MODE_BITS:     mode_q         <= cfg_data_i[MODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: every stage advances together unless the output
  // register holds a frame the receiver has not taken.
  // ---------------------------------------------------------------------
  logic adv;
  logic v1_q, v2_q, v3_q;

  assign adv         = !v3_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: right-channel selection, dry and return products
  // ---------------------------------------------------------------------
  sample_t raw_l, raw_r;
  sample_t ret_l [NUM_BUS];
  sample_t ret_r [NUM_BUS];
  sample_t ret_in_r [NUM_BUS];
  sample_t dry_l, dry_r;
  sample_t retg_l [NUM_BUS];
  sample_t retg_r [NUM_BUS];

  assign raw_l       = main_left_i;
  assign raw_r       = mode_q[MODE_MAIN_R] ? main_right_i : main_left_i;
  assign ret_l[0]    = ret_a_left_i;
  assign ret_l[1]    = ret_b_left_i;
  assign ret_l[2]    = ret_c_left_i;
  assign ret_in_r[0] = ret_a_right_i;
  assign ret_in_r[1] = ret_b_right_i;
  assign ret_in_r[2] = ret_c_right_i;

  asrm_gain u_dry_l (.s_i(raw_l), .g_i(dry_gain_q), .y_o(dry_l));
  asrm_gain u_dry_r (.s_i(raw_r), .g_i(dry_gain_q), .y_o(dry_r));

  for (genvar b = 0; b < NUM_BUS; b++) begin : g_ret
    // absent right input copies its left
    assign ret_r[b] = mode_q[MODE_RET_R_A+b] ? ret_in_r[b] : ret_l[b];
    asrm_gain u_ret_l (.s_i(ret_l[b]), .g_i(ret_gain_q[b]), .y_o(retg_l[b]));
    asrm_gain u_ret_r (.s_i(ret_r[b]), .g_i(ret_gain_q[b]), .y_o(retg_r[b]));
  end

  sample_t s1_raw_l_q, s1_raw_r_q, s1_dry_l_q, s1_dry_r_q;
  sample_t s1_ret_l_q [NUM_BUS];
  sample_t s1_ret_r_q [NUM_BUS];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_raw_l_q <= raw_l;
      s1_raw_r_q <= raw_r;
      s1_dry_l_q <= dry_l;
      s1_dry_r_q <= dry_r;
      for (int i = 0; i < NUM_BUS; i++) begin
        s1_ret_l_q[i] <= retg_l[i];
        s1_ret_r_q[i] <= retg_r[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: send products and the unclamped mix sum
  // ---------------------------------------------------------------------
  sample_t src_l [NUM_BUS];
  sample_t src_r [NUM_BUS];
  sample_t snd_l [NUM_BUS];
  sample_t snd_r [NUM_BUS];
  mix_t    sum_l, sum_r;

  for (genvar b = 0; b < NUM_BUS; b++) begin : g_send
    // pre-fader takes the raw input, post-fader the rounded dry value
    assign src_l[b] = mode_q[MODE_PRE_A+b] ? s1_raw_l_q : s1_dry_l_q;
    assign src_r[b] = mode_q[MODE_PRE_A+b] ? s1_raw_r_q : s1_dry_r_q;
    asrm_gain u_snd_l (.s_i(src_l[b]), .g_i(send_gain_q[b]), .y_o(snd_l[b]));
    asrm_gain u_snd_r (.s_i(src_r[b]), .g_i(send_gain_q[b]), .y_o(snd_r[b]));
  end

  assign sum_l = mix_t'(s1_dry_l_q) + mix_t'(s1_ret_l_q[0])
               + mix_t'(s1_ret_l_q[1]) + mix_t'(s1_ret_l_q[2]);
  assign sum_r = mix_t'(s1_dry_r_q) + mix_t'(s1_ret_r_q[0])
               + mix_t'(s1_ret_r_q[1]) + mix_t'(s1_ret_r_q[2]);

  sample_t s2_snd_l_q [NUM_BUS];
  sample_t s2_snd_r_q [NUM_BUS];
  mix_t    s2_sum_l_q, s2_sum_r_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NUM_BUS; i++) begin
        s2_snd_l_q[i] <= snd_l[i];
        s2_snd_r_q[i] <= snd_r[i];
      end
      s2_sum_l_q <= sum_l;
      s2_sum_r_q <= sum_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: clamp the mix to +/- 10 V, output register
  // ---------------------------------------------------------------------
  sample_t clamp_l, clamp_r;

  always_comb begin
    if (s2_sum_l_q > MIX_MAX_W) begin
      clamp_l = MIX_MAX;
    end else if (s2_sum_l_q < MIX_MIN_W) begin
      clamp_l = MIX_MIN;
    end else begin
      clamp_l = s2_sum_l_q[SAMPLE_BITS-1:0];
    end
    if (s2_sum_r_q > MIX_MAX_W) begin
      clamp_r = MIX_MAX;
    end else if (s2_sum_r_q < MIX_MIN_W) begin
      clamp_r = MIX_MIN;
    end else begin
      clamp_r = s2_sum_r_q[SAMPLE_BITS-1:0];
    end
  end

  sample_t s3_snd_l_q [NUM_BUS];
  sample_t s3_snd_r_q [NUM_BUS];
  sample_t s3_mix_l_q, s3_mix_r_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NUM_BUS; i++) begin
        s3_snd_l_q[i] <= s2_snd_l_q[i];
        s3_snd_r_q[i] <= s2_snd_r_q[i];
      end
      s3_mix_l_q <= clamp_l;
      s3_mix_r_q <= clamp_r;
    end
  end

  assign send_a_left_o  = s3_snd_l_q[0];
  assign send_a_right_o = s3_snd_r_q[0];
  assign send_b_left_o  = s3_snd_l_q[1];
  assign send_b_right_o = s3_snd_r_q[1];
  assign send_c_left_o  = s3_snd_l_q[2];
  assign send_c_right_o = s3_snd_r_q[2];
  assign mix_left_o     = s3_mix_l_q;
  assign mix_right_o    = s3_mix_r_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_mix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mix_left_o <= MIX_MAX) && (mix_left_o >= MIX_MIN) &&
                    (mix_right_o <= MIX_MAX) && (mix_right_o >= MIX_MIN))
    else $error("mix output outside +/- 10 V");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted frame did not enter stage 1");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(v1_q) && $stable(v2_q) && v3_q)
    else $error("pipeline moved during output stall");

  a_gain_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dry_gain_q <= UNITY_GAIN) && (send_gain_q[0] <= UNITY_GAIN) &&
    (send_gain_q[1] <= UNITY_GAIN) && (send_gain_q[2] <= UNITY_GAIN) &&
    (ret_gain_q[0] <= UNITY_GAIN) && (ret_gain_q[1] <= UNITY_GAIN) &&
    (ret_gain_q[2] <= UNITY_GAIN))
    else $error("stored gain above unity");

endmodule

/* dv/aux_send_return_mixer_top_tb.sv */
// Testbench for aux_send_return_mixer_top: directed and random stereo frames
// under several gain and mode settings, checked by a mix predictor in a scoreboard.
// Depends on asrm_pkg and the mixer RTL.
`timescale 1ns / 1ps

module aux_send_return_mixer_top_tb;
  import asrm_pkg::*;

  localparam int     CLK_HALF         = 6;
  localparam int     PIPE_LATENCY     = 3;
  localparam int     LONG_STALL       = 200;
  localparam int     RAND_PER_SETTING = 50;
  localparam int     MAX_REPORTS      = 40;
  localparam longint TIMEOUT_NS       = 3_000_000;
  localparam longint ROUND_BIAS       = 32768;
  localparam longint MIX_LIMIT        = longint'(10) << FRAC_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LO = 4'd8;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_HI = 4'd15;

  localparam sample_t SMP_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMP_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam gain_t   GAIN_ZERO = '0;
  localparam gain_t   GAIN_FULL = '1;
  localparam mode_t   MODE_ALT  = 7'b1010101;

  // sender idle and receiver stall percentages per random phase
  localparam int SRC_IDLE[4]   = '{0, 88, 0, 16};
  localparam int SINK_STALL[4] = '{0, 0, 88, 16};

  typedef struct packed {
    sample_t main_left;
    sample_t main_right;
    sample_t ret_a_left;
    sample_t ret_a_right;
    sample_t ret_b_left;
    sample_t ret_b_right;
    sample_t ret_c_left;
    sample_t ret_c_right;
  } frame_t;

  typedef struct packed {
    sample_t send_a_left;
    sample_t send_a_right;
    sample_t send_b_left;
    sample_t send_b_right;
    sample_t send_c_left;
    sample_t send_c_right;
    sample_t mix_left;
    sample_t mix_right;
  } mix_out_t;

  class mix_scoreboard;
    gain_t    dry_gain;
    gain_t    send_gain[3];
    gain_t    ret_gain[3];
    mode_t    mode;
    mix_out_t expected_mix_q[$];
    int       fails;

    function new();
      dry_gain = UNITY_GAIN;
      foreach (send_gain[i]) send_gain[i] = HALF_GAIN;
      foreach (ret_gain[i]) ret_gain[i] = HALF_GAIN;
      mode  = '0;
      fails = 0;
    endfunction

    // round to nearest LSB, ties up; gains above unity act as unity
    function longint scaled(longint smp, gain_t g);
      gain_t  eff;
      longint p;
      eff = (g > UNITY_GAIN) ? UNITY_GAIN : g;
      p   = smp * longint'(eff) + ROUND_BIAS;
      return p >>> GAIN_FRAC;
    endfunction

    function longint clamped(longint v);
      if (v > MIX_LIMIT) return MIX_LIMIT;
      if (v < -MIX_LIMIT) return -MIX_LIMIT;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, gain_t data);
      case (idx)
        CFG_DRY_GAIN:      dry_gain = data;
        CFG_SEND_A_GAIN:   send_gain[0] = data;
        CFG_SEND_B_GAIN:   send_gain[1] = data;
        CFG_SEND_C_GAIN:   send_gain[2] = data;
        CFG_RETURN_A_GAIN: ret_gain[0] = data;
        CFG_RETURN_B_GAIN: ret_gain[1] = data;
        CFG_RETURN_C_GAIN: ret_gain[2] = data;
        CFG_MODE_BITS:     mode = data[MODE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_frame(frame_t f);
      sample_t  ret_l[3];
      sample_t  ret_r[3];
      longint   raw_l, raw_r, dry_l, dry_r, mix_l, mix_r;
      longint   snd_l[3];
      longint   snd_r[3];
      int       i;
      mix_out_t e;
      ret_l = '{f.ret_a_left, f.ret_b_left, f.ret_c_left};
      ret_r = '{f.ret_a_right, f.ret_b_right, f.ret_c_right};
      raw_l = f.main_left;
      raw_r = mode[MODE_MAIN_R] ? f.main_right : f.main_left;
      dry_l = scaled(raw_l, dry_gain);
      dry_r = scaled(raw_r, dry_gain);
      mix_l = dry_l;
      mix_r = dry_r;
      for (i = 0; i < NUM_BUS; i++) begin
        // pre-fader taps the raw input, post-fader the rounded dry value
        snd_l[i] = scaled(mode[MODE_PRE_A + i] ? raw_l : dry_l, send_gain[i]);
        snd_r[i] = scaled(mode[MODE_PRE_A + i] ? raw_r : dry_r, send_gain[i]);
        mix_l += scaled(ret_l[i], ret_gain[i]);
        mix_r += scaled(mode[MODE_RET_R_A + i] ? ret_r[i] : ret_l[i], ret_gain[i]);
      end
      e.send_a_left  = sample_t'(snd_l[0]);
      e.send_a_right = sample_t'(snd_r[0]);
      e.send_b_left  = sample_t'(snd_l[1]);
      e.send_b_right = sample_t'(snd_r[1]);
      e.send_c_left  = sample_t'(snd_l[2]);
      e.send_c_right = sample_t'(snd_r[2]);
      e.mix_left     = sample_t'(clamped(mix_l));
      e.mix_right    = sample_t'(clamped(mix_r));
      expected_mix_q.push_back(e);
    endfunction

    function int pending();
      return expected_mix_q.size();
    endfunction

    task report_mismatch(string msg);
      fails++;
      // keep the log short on a badly broken design
      if (fails <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task compare_field(string name, sample_t got, sample_t want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_frame(mix_out_t got);
      mix_out_t want;
      if (expected_mix_q.size() == 0) begin
        report_mismatch("output transfer with no frame pending");
        return;
      end
      want = expected_mix_q.pop_front();
      compare_field("send_a_left", got.send_a_left, want.send_a_left);
      compare_field("send_a_right", got.send_a_right, want.send_a_right);
      compare_field("send_b_left", got.send_b_left, want.send_b_left);
      compare_field("send_b_right", got.send_b_right, want.send_b_right);
      compare_field("send_c_left", got.send_c_left, want.send_c_left);
      compare_field("send_c_right", got.send_c_right, want.send_c_right);
      compare_field("mix_left", got.mix_left, want.mix_left);
      compare_field("mix_right", got.mix_right, want.mix_right);
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  gain_t                   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  frame_t                  in_frame;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  mix_out_t                out_frame;

  int            src_idle_pct;
  int            sink_stall_pct;
  bit            long_stall_req;
  int            stall_left;
  mix_scoreboard sb;

  aux_send_return_mixer_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .main_left_i    (in_frame.main_left),
    .main_right_i   (in_frame.main_right),
    .ret_a_left_i   (in_frame.ret_a_left),
    .ret_a_right_i  (in_frame.ret_a_right),
    .ret_b_left_i   (in_frame.ret_b_left),
    .ret_b_right_i  (in_frame.ret_b_right),
    .ret_c_left_i   (in_frame.ret_c_left),
    .ret_c_right_i  (in_frame.ret_c_right),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .send_a_left_o  (out_frame.send_a_left),
    .send_a_right_o (out_frame.send_a_right),
    .send_b_left_o  (out_frame.send_b_left),
    .send_b_right_o (out_frame.send_b_right),
    .send_c_left_o  (out_frame.send_c_left),
    .send_c_right_o (out_frame.send_c_right),
    .mix_left_o     (out_frame.mix_left),
    .mix_right_o    (out_frame.mix_right)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (long_stall_req) begin
      stall_left     = LONG_STALL;
      long_stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_frame(in_frame);
      if (out_valid_o && out_ready_i) sb.check_frame(out_frame);
    end
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return sample_t'(int'($urandom_range(512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic gain_t rand_gain();
    case ($urandom_range(9))
      0: return GAIN_ZERO;
      1: return UNITY_GAIN;
      2: return gain_t'($urandom_range(GAIN_FULL, UNITY_GAIN + 1));
      default: return gain_t'($urandom_range(UNITY_GAIN));
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    f.main_left   = rand_sample();
    f.main_right  = rand_sample();
    f.ret_a_left  = rand_sample();
    f.ret_a_right = rand_sample();
    f.ret_b_left  = rand_sample();
    f.ret_b_right = rand_sample();
    f.ret_c_left  = rand_sample();
    f.ret_c_right = rand_sample();
    return f;
  endfunction

  function automatic frame_t uniform_frame(sample_t v);
    return frame_t'({8{v}});
  endfunction

  // hold valid and payload until the transfer
  task automatic push_frame(frame_t f);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_frame   <= f;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, gain_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic load_config(gain_t dry, gain_t s_a, gain_t s_b, gain_t s_c,
                             gain_t r_a, gain_t r_b, gain_t r_c, mode_t m,
                             bit poke_unused);
    gain_t mode_word;
    // upper bits of the mode write carry noise
    mode_word = gain_t'($urandom);
    mode_word[MODE_BITS-1:0] = m;
    write_reg(CFG_DRY_GAIN, dry);
    write_reg(CFG_SEND_A_GAIN, s_a);
    write_reg(CFG_SEND_B_GAIN, s_b);
    write_reg(CFG_SEND_C_GAIN, s_c);
    write_reg(CFG_RETURN_A_GAIN, r_a);
    write_reg(CFG_RETURN_B_GAIN, r_b);
    write_reg(CFG_RETURN_C_GAIN, r_c);
    write_reg(CFG_MODE_BITS, mode_word);
    if (poke_unused)
      write_reg(CFG_IDX_BITS'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)),
                gain_t'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_config();
    load_config(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                rand_gain(), rand_gain(), rand_gain(), mode_t'($urandom),
                bit'($urandom_range(1)));
  endtask

  // drop valid and wait until every frame has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  initial begin
    int ph;
    int st;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    in_frame       = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    long_stall_req = 1'b0;
    stall_left     = 0;
    sb             = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset gains: half-gain ties on +1 and -1
    push_frame(uniform_frame('0));
    push_frame(uniform_frame(SMP_MAX));
    push_frame(uniform_frame(SMP_MIN));
    push_frame(uniform_frame(sample_t'(-1)));
    push_frame(uniform_frame(sample_t'(1)));
    push_frame(random_frame());
    drain();

    // unity everywhere, all pre-fader, all right inputs present: mix clamps
    load_config(UNITY_GAIN, UNITY_GAIN, UNITY_GAIN, UNITY_GAIN,
                UNITY_GAIN, UNITY_GAIN, UNITY_GAIN, '1, 1'b0);
    push_frame(uniform_frame(SMP_MAX));
    push_frame(uniform_frame(SMP_MIN));
    push_frame(random_frame());
    push_frame(random_frame());
    drain();

    // every bus unused, post-fader, right inputs absent
    load_config(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO,
                GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, '0, 1'b0);
    push_frame(uniform_frame(SMP_MAX));
    push_frame(random_frame());
    push_frame(random_frame());
    drain();

    // gains above unity, mixed mode, plus a write to an unknown index
    load_config(GAIN_FULL, gain_t'(UNITY_GAIN + 1), gain_t'(UNITY_GAIN + 1),
                gain_t'(UNITY_GAIN + 1), GAIN_FULL, GAIN_FULL, GAIN_FULL,
                MODE_ALT, 1'b1);
    push_frame(uniform_frame(SMP_MAX));
    push_frame(uniform_frame(SMP_MIN));
    push_frame(random_frame());
    push_frame(random_frame());
    drain();

    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct   = SRC_IDLE[ph];
      sink_stall_pct = SINK_STALL[ph];
      for (st = 0; st < 2; st++) begin
        random_config();
        // back-pressure: sender keeps offering while the sink holds off
        if (ph == 0 && st == 0) long_stall_req = 1'b1;
        repeat (RAND_PER_SETTING) push_frame(random_frame());
        drain();
      end
    end

    if (sb.fails == 0) begin
      $display("aux_send_return_mixer_top verification clean");
    end else begin
      $display("aux_send_return_mixer_top verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("aux_send_return_mixer_top verification failed");
    $finish;
  end

endmodule
